>>> src/ulc_pkg.sv
// ---------------------------------------------------------------------------
// ulc_pkg
// Shared types, constants and byte classification for the UTF-8 likelihood
// checker.
// ---------------------------------------------------------------------------
package ulc_pkg;

    // Default width of the saturating sequence and byte counters.
    localparam int unsigned COUNT_BITS_DEFAULT = 32;

    // Register map.
    localparam int unsigned APB_ADDR_BITS  = 3;
    localparam int unsigned APB_DATA_BITS  = 32;
    localparam int unsigned REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_THRESHOLD = 1'b0;

    localparam int unsigned THRESHOLD_BITS = 7;
    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 7'd90;

    localparam int unsigned OUT_COUNT_BITS = 32;
    localparam int unsigned RUN_BITS       = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic                      is_utf8;
        logic [OUT_COUNT_BITS-1:0] valid_sequences;
        logic [OUT_COUNT_BITS-1:0] invalid_bytes;
    } result_item_t;

    // Number of continuation bytes a lead byte announces; zero for ASCII and
    // for bytes that cannot start a sequence.
    function automatic logic [RUN_BITS-1:0] lead_need(input logic [7:0] b);
        logic [RUN_BITS-1:0] need;
        need = '0;
        priority if (b[7] == 1'b0)          need = 3'd0;
        else if (b[7:5] == 3'b110)          need = 3'd1;
        else if (b[7:4] == 4'b1110)         need = 3'd2;
        else if (b[7:3] == 5'b11110)        need = 3'd3;
        else if (b[7:2] == 6'b111110)       need = 3'd4;
        else if (b[7:1] == 7'b1111110)      need = 3'd5;
        else                                need = 3'd0;
        return need;
    endfunction

    // A stray continuation byte, 0xFE or 0xFF: none of these can open a run.
    function automatic logic lead_bad(input logic [7:0] b);
        return (b[7:6] == 2'b10) || (b[7:1] == 7'b1111111);
    endfunction

endpackage

>>> src/ulc_apb_regs.sv
// ---------------------------------------------------------------------------
// ulc_apb_regs
// APB register slave holding the verdict threshold.
// ---------------------------------------------------------------------------
module ulc_apb_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ulc_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [ulc_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [ulc_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready,
    output logic [ulc_pkg::THRESHOLD_BITS-1:0]     threshold
);

    logic [ulc_pkg::REG_INDEX_BITS-1:0] reg_index;
    logic [ulc_pkg::THRESHOLD_BITS-1:0] threshold_reg;
    logic [ulc_pkg::THRESHOLD_BITS-1:0] threshold_next;

    assign reg_index = paddr[ulc_pkg::APB_ADDR_BITS-1:2];
    assign pready    = 1'b1;
    assign threshold = threshold_reg;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && (reg_index == ulc_pkg::REG_THRESHOLD))
        begin
            threshold_next = pwdata[ulc_pkg::THRESHOLD_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == ulc_pkg::REG_THRESHOLD)
        begin
            prdata = ulc_pkg::APB_DATA_BITS'(threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ulc_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

endmodule

>>> src/ulc_byte_scan.sv
// ---------------------------------------------------------------------------
// ulc_byte_scan
// Input register, run tracking and saturating counters. Hands the final
// counts of each text to the verdict pipeline.
// ---------------------------------------------------------------------------
module ulc_byte_scan #(
    parameter int unsigned COUNT_BITS = ulc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  ulc_pkg::byte_item_t     byte_item,
    output logic                    tally_valid,
    input  logic                    tally_ready,
    output logic [COUNT_BITS-1:0]   tally_valid_count,
    output logic [COUNT_BITS-1:0]   tally_invalid_count
);

    localparam int unsigned RB = ulc_pkg::RUN_BITS;

    logic                   s0_valid_reg, s0_valid_next;
    ulc_pkg::byte_item_t    s0_item_reg;
    logic [RB-1:0]          need_reg, need_next;
    logic [RB-1:0]          seen_reg, seen_next;
    logic [COUNT_BITS-1:0]  vcnt_reg, vcnt_next;
    logic [COUNT_BITS-1:0]  icnt_reg, icnt_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [COUNT_BITS-1:0]  s1_vcnt_reg;
    logic [COUNT_BITS-1:0]  s1_icnt_reg;

    logic [7:0]             b;
    logic                   is_cont;
    logic [RB-1:0]          seen_inc;
    logic [RB-1:0]          need_a, seen_a;
    logic                   v_inc;
    logic [RB-1:0]          i_inc;
    logic [COUNT_BITS:0]    v_sum, i_sum;
    logic [COUNT_BITS-1:0]  v_new, i_new;
    logic                   s0_adv;
    logic                   s1_free;

    assign b        = s0_item_reg.data_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign seen_inc = seen_reg + RB'(1);

    // Byte effect on the open run, then the end-of-text flush of what is
    // still open. Both invalid contributions fold into one increment.
    always_comb
    begin
        need_a = need_reg;
        seen_a = seen_reg;
        v_inc  = 1'b0;
        i_inc  = '0;
        if (s0_item_reg.byte_present)
        begin
            if ((need_reg != '0) && is_cont)
            begin
                if (seen_inc >= need_reg)
                begin
                    v_inc  = 1'b1;
                    need_a = '0;
                    seen_a = '0;
                end
                else
                begin
                    seen_a = seen_inc;
                end
            end
            else
            begin
                if (need_reg != '0)
                begin
                    i_inc = seen_inc;
                end
                need_a = ulc_pkg::lead_need(b);
                seen_a = '0;
                if (ulc_pkg::lead_bad(b))
                begin
                    i_inc = i_inc + RB'(1);
                end
            end
        end
        if (s0_item_reg.end_of_text && (need_a != '0))
        begin
            i_inc = i_inc + seen_a + RB'(1);
        end
    end

    assign v_sum = {1'b0, vcnt_reg} + (COUNT_BITS+1)'(v_inc);
    assign i_sum = {1'b0, icnt_reg} + (COUNT_BITS+1)'(i_inc);
    assign v_new = v_sum[COUNT_BITS] ? '1 : v_sum[COUNT_BITS-1:0];
    assign i_new = i_sum[COUNT_BITS] ? '1 : i_sum[COUNT_BITS-1:0];

    // Only an end-of-text item needs room downstream; others retire here.
    assign s1_free    = !s1_valid_reg || tally_ready;
    assign s0_adv     = s0_valid_reg && (!s0_item_reg.end_of_text || s1_free);
    assign byte_ready = !s0_valid_reg || s0_adv;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        need_next     = need_reg;
        seen_next     = seen_reg;
        vcnt_next     = vcnt_reg;
        icnt_next     = icnt_reg;
        s1_valid_next = s1_valid_reg;
        if (byte_ready)
        begin
            s0_valid_next = byte_valid;
        end
        if (tally_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (s0_adv)
        begin
            if (s0_item_reg.end_of_text)
            begin
                need_next     = '0;
                seen_next     = '0;
                vcnt_next     = '0;
                icnt_next     = '0;
                s1_valid_next = 1'b1;
            end
            else
            begin
                need_next = need_a;
                seen_next = seen_a;
                vcnt_next = v_new;
                icnt_next = i_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            need_reg     <= '0;
            seen_reg     <= '0;
            vcnt_reg     <= '0;
            icnt_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            need_reg     <= need_next;
            seen_reg     <= seen_next;
            vcnt_reg     <= vcnt_next;
            icnt_reg     <= icnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            s0_item_reg <= byte_item;
        end
        if (s0_adv && s0_item_reg.end_of_text)
        begin
            s1_vcnt_reg <= v_new;
            s1_icnt_reg <= i_new;
        end
    end

    assign tally_valid         = s1_valid_reg;
    assign tally_valid_count   = s1_vcnt_reg;
    assign tally_invalid_count = s1_icnt_reg;

endmodule

>>> src/ulc_verdict.sv
// ---------------------------------------------------------------------------
// ulc_verdict
// Three-stage pipeline (s2, s3 and the output register) that turns the
// final counts of a text into the verdict.
// ---------------------------------------------------------------------------
module ulc_verdict #(
    parameter int unsigned COUNT_BITS = ulc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ulc_pkg::THRESHOLD_BITS-1:0]  threshold,
    input  logic                                tally_valid,
    output logic                                tally_ready,
    input  logic [COUNT_BITS-1:0]               tally_valid_count,
    input  logic [COUNT_BITS-1:0]               tally_invalid_count,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ulc_pkg::result_item_t               result_item
);

    localparam int unsigned OB    = ulc_pkg::OUT_COUNT_BITS;
    localparam int unsigned TB    = ulc_pkg::THRESHOLD_BITS + 1;
    localparam int unsigned TOT_W = COUNT_BITS + 1;
    localparam int unsigned PV_W  = COUNT_BITS + 7;
    localparam int unsigned PT_W  = TOT_W + TB;

    logic                  s2_valid_reg, s2_valid_next;
    logic [TOT_W-1:0]      s2_total_reg;
    logic [PV_W-1:0]       s2_pv_reg;
    logic [OB-1:0]         s2_vlo_reg, s2_ilo_reg;

    logic                  s3_valid_reg, s3_valid_next;
    logic [PT_W-1:0]       s3_pt_reg;
    logic [PV_W-1:0]       s3_pv_reg;
    logic [OB-1:0]         s3_vlo_reg, s3_ilo_reg;

    logic                  out_valid_reg, out_valid_next;
    ulc_pkg::result_item_t out_item_reg;

    logic                  out_free, take3, take2;
    logic [PV_W-1:0]       v_ext;
    logic [TB-1:0]         thr_plus;

    // floor(100*v/t) > T holds exactly when 100*v >= (T+1)*t; an empty text
    // (t = 0) gives 0 >= 0 and so a UTF-8 verdict with no special case.
    assign v_ext    = PV_W'(tally_valid_count);
    assign thr_plus = TB'(threshold) + TB'(1);

    assign out_free    = !out_valid_reg || result_ready;
    assign take3       = !s3_valid_reg || out_free;
    assign take2       = !s2_valid_reg || take3;
    assign tally_ready = take2;

    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        out_valid_next = out_valid_reg;
        if (take2)
        begin
            s2_valid_next = tally_valid;
        end
        if (take3)
        begin
            s3_valid_next = s2_valid_reg;
        end
        if (out_free)
        begin
            out_valid_next = s3_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take2 && tally_valid)
        begin
            s2_total_reg <= TOT_W'(tally_valid_count) + TOT_W'(tally_invalid_count);
            s2_pv_reg    <= (v_ext << 6) + (v_ext << 5) + (v_ext << 2);
            s2_vlo_reg   <= OB'(tally_valid_count);
            s2_ilo_reg   <= OB'(tally_invalid_count);
        end
        if (take3 && s2_valid_reg)
        begin
            s3_pt_reg  <= PT_W'(s2_total_reg) * PT_W'(thr_plus);
            s3_pv_reg  <= s2_pv_reg;
            s3_vlo_reg <= s2_vlo_reg;
            s3_ilo_reg <= s2_ilo_reg;
        end
        if (out_free && s3_valid_reg)
        begin
            out_item_reg.is_utf8         <= (PT_W'(s3_pv_reg) >= s3_pt_reg);
            out_item_reg.valid_sequences <= s3_vlo_reg;
            out_item_reg.invalid_bytes   <= s3_ilo_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

>>> src/utf8_likelihood_checker.sv
// ---------------------------------------------------------------------------
// utf8_likelihood_checker
// Judges whether a byte stream is likely UTF-8 text.
// ---------------------------------------------------------------------------
// The block takes one byte item per clock cycle while the verdict pipeline
// has room for end_of_text items: the run and counter update for a byte is
// done in the cycle after it is registered, and items that do not end a
// text retire there. An item marked end_of_text produces one result item
// after it has passed the tally register and the verdict pipeline (sum,
// threshold multiply, compare); later texts stream in behind it meanwhile.
// Both counters saturate at 2^COUNT_BITS - 1 and the result shows their low
// 32 bits. The threshold is set through the APB register at byte address 0
// and should only be changed while no text is in flight.
module utf8_likelihood_checker #(
    parameter int unsigned COUNT_BITS = ulc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ulc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ulc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ulc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  ulc_pkg::byte_item_t                 byte_item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ulc_pkg::result_item_t               result_item
);

    logic [ulc_pkg::THRESHOLD_BITS-1:0] threshold;
    logic                               tally_valid;
    logic                               tally_ready;
    logic [COUNT_BITS-1:0]              tally_valid_count;
    logic [COUNT_BITS-1:0]              tally_invalid_count;

    ulc_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    ulc_byte_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_ready          (byte_ready),
        .byte_item           (byte_item),
        .tally_valid         (tally_valid),
        .tally_ready         (tally_ready),
        .tally_valid_count   (tally_valid_count),
        .tally_invalid_count (tally_invalid_count)
    );

    ulc_verdict #(
        .COUNT_BITS (COUNT_BITS)
    ) u_verdict (
        .clk                 (clk),
        .rst_n               (rst_n),
        .threshold           (threshold),
        .tally_valid         (tally_valid),
        .tally_ready         (tally_ready),
        .tally_valid_count   (tally_valid_count),
        .tally_invalid_count (tally_invalid_count),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .result_item         (result_item)
    );

endmodule

>>> src/ulc_checker.sv
// ---------------------------------------------------------------------------
// ulc_checker
// Port-level checks on the UTF-8 likelihood checker, bound to the top level.
// ---------------------------------------------------------------------------
module ulc_checker #(
    parameter int unsigned COUNT_BITS = ulc_pkg::COUNT_BITS_DEFAULT
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                psel,
    input logic                                pready,
    input logic                                byte_ready,
    input logic                                result_valid,
    input logic                                result_ready,
    input ulc_pkg::result_item_t               result_item
);

    localparam logic FULL_COUNTS = (COUNT_BITS <= ulc_pkg::OUT_COUNT_BITS);

    // A waiting result is held until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item changed or dropped while stalled");

    // With the sink taking results, the pipeline drains and input never stalls.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> byte_ready)
        else $error("input stalled although the result side is ready");

    // A text with no multi-byte sequence and no bad byte is judged UTF-8.
    a_empty_is_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && FULL_COUNTS && (result_item.valid_sequences == '0)
            && (result_item.invalid_bytes == '0) |-> result_item.is_utf8)
        else $error("clean text not judged UTF-8");

    // Only bad bytes and no valid sequence can never pass the threshold.
    a_all_bad_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && FULL_COUNTS && (result_item.valid_sequences == '0)
            && (result_item.invalid_bytes != '0) |-> !result_item.is_utf8)
        else $error("text with only bad bytes judged UTF-8");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during an access");

endmodule

bind utf8_likelihood_checker ulc_checker #(.COUNT_BITS(COUNT_BITS)) u_ulc_checker (.*);
